@@ hdl/lqs_pkg.sv @@
// ----------------------------------------------------------------------------
// lqs_pkg
// Shared types, constants and helpers of the line to quad strip expander.
// ----------------------------------------------------------------------------
`default_nettype none

package lqs_pkg;

  localparam int unsigned MAX_STEPS_DEF = 16;

  // fixed widths
  localparam int unsigned NUM_W = 63;   // divider numerator
  localparam int unsigned SQ_W  = 66;   // sum of squares
  localparam int unsigned RT_W  = 33;   // square root
  localparam int unsigned UQ_W  = 49;   // U accumulator quotient
  localparam int unsigned POS_W = 35;   // boundary position
  localparam int unsigned U_W   = 52;   // boundary U before saturation

  // register map
  localparam logic [1:0] REG_HALF_WIDTH = 2'd0;
  localparam logic [1:0] REG_STEP_LEN   = 2'd1;
  localparam logic [1:0] REG_TEX_LEN    = 2'd2;
  localparam logic [1:0] REG_TEX_LOOP   = 2'd3;

  localparam logic [30:0] HALF_WIDTH_RST = 31'd32768;
  localparam logic [30:0] STEP_LEN_RST   = 31'd131072;
  localparam logic [30:0] TEX_LEN_RST    = 31'd131072;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_MIDDLE = 2'd1;
  localparam logic [1:0] KIND_FINAL  = 2'd2;

  localparam logic [1:0] V_ZERO = 2'd0;
  localparam logic [1:0] V_HALF = 2'd1;
  localparam logic [1:0] V_ONE  = 2'd2;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;
  localparam logic [1:0] CORNER_3 = 2'd3;

  typedef enum logic [2:0] {
    OP_OX, OP_OY, OP_PX, OP_PY, OP_PZ, OP_PU, OP_LOOP
  } lqs_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT_GO, S_SQRT_WAIT, S_COUNT,
    S_DIV_GO, S_DIV_WAIT, S_INIT, S_ADV, S_EMIT
  } lqs_state_e;

  typedef struct packed {
    logic       load;
    logic       sq_en;
    logic [1:0] axis;
    logic       sqrt_start;
    logic       sqrt_store;
    logic       sqrt_sel;     // 0: full length, 1: xy length
    logic       cnt_init;
    logic       cnt_step;
    logic       div_start;
    logic       div_store;
    lqs_op_e    op;
    logic       init;
    logic       adv;
    logic       emit;
    logic [1:0] corner;
  } lqs_cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic cnt_done;
    logic last_step;
    logic out_free;
  } lqs_sts_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/lqs_div.sv @@
// ----------------------------------------------------------------------------
// lqs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_div #(
  parameter int unsigned NW = 63,
  parameter int unsigned DW = 35
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               busy_o,
  output logic [NW-1:0]      quo_o,
  output logic [DW-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(NW);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NW-1:0]    num_q;
  logic [DW-1:0]    rem_q, den_q;
  logic [DW:0]      trial, diff;
  logic             ge;

  assign trial = {rem_q, num_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ hdl/lqs_sqrt.sv @@
// ----------------------------------------------------------------------------
// lqs_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_sqrt
  import lqs_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SQ_W-1:0] rad_i,
  output logic                 busy_o,
  output logic [RT_W-1:0]      root_o
);

  logic            busy_q;
  logic [5:0]      cnt_q;
  logic [SQ_W-1:0] rad_q;
  logic [RT_W-1:0] root_q;
  logic [RT_W+1:0] rem_q;
  logic [RT_W+3:0] trial, sub, diff;
  logic            ge;

  assign trial = {rem_q, rad_q[SQ_W-1 -: 2]};
  assign sub   = {2'b00, root_q, 2'b01};
  assign ge    = trial >= sub;
  assign diff  = trial - sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == 6'(RT_W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
      root_q <= {root_q[RT_W-2:0], ge};
      rem_q  <= ge ? diff[RT_W+1:0] : trial[RT_W+1:0];
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

@@ hdl/lqs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lqs_ctrl
// Sequencer: squares, roots, step count, divisions, then vertex emission.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_ctrl
  import lqs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire lqs_sts_t sts_i,
  output lqs_cmd_t      cmd_o
);

  lqs_state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       sel_q, sel_d;
  lqs_op_e    op_q, op_d;
  logic [1:0] corner_q, corner_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      axis_q   <= AX_X;
      sel_q    <= 1'b0;
      op_q     <= OP_OX;
      corner_q <= CORNER_0;
    end else begin
      state_q  <= state_d;
      axis_q   <= axis_d;
      sel_q    <= sel_d;
      op_q     <= op_d;
      corner_q <= corner_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    sel_d      = sel_q;
    op_d       = op_q;
    corner_d   = corner_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    cmd_o.sqrt_sel = sel_q;
    cmd_o.op   = op_q;
    cmd_o.corner = corner_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          axis_d     = AX_X;
          state_d    = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_en = 1'b1;
        if (axis_q == AX_Z) begin
          sel_d   = 1'b0;
          state_d = S_SQRT_GO;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      S_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (!sts_i.sqrt_busy) begin
          cmd_o.sqrt_store = 1'b1;
          if (!sel_q) begin
            sel_d   = 1'b1;
            state_d = S_SQRT_GO;
          end else begin
            cmd_o.cnt_init = 1'b1;
            state_d = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        if (sts_i.cnt_done) begin
          op_d    = OP_OX;
          state_d = S_DIV_GO;
        end else begin
          cmd_o.cnt_step = 1'b1;
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.div_store = 1'b1;
          state_d = S_DIV_GO;
          case (op_q)
            OP_OX:   op_d = OP_OY;
            OP_OY:   op_d = OP_PX;
            OP_PX:   op_d = OP_PY;
            OP_PY:   op_d = OP_PZ;
            OP_PZ:   op_d = OP_PU;
            OP_PU:   op_d = OP_LOOP;
            default: state_d = S_INIT;
          endcase
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d = S_ADV;
      end
      S_ADV: begin
        cmd_o.adv = 1'b1;
        corner_d  = CORNER_0;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (corner_q == CORNER_3) begin
            state_d = sts_i.last_step ? S_IDLE : S_ADV;
          end else begin
            corner_d = corner_q + 2'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/lqs_datapath.sv @@
// ----------------------------------------------------------------------------
// lqs_datapath
// Operand registers, length and offset math, boundary stepping, vertex output.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_datapath
  import lqs_pkg::*;
#(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lqs_cmd_t      cmd_i,
  output lqs_sts_t           sts_o,
  input  wire logic [30:0]   half_width_i,
  input  wire logic [30:0]   step_length_i,
  input  wire logic [30:0]   texture_length_i,
  input  wire logic          force_tex_loop_i,
  input  wire logic [223:0]  in_data_i,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output logic [135:0]       m_data_o,
  output logic [1:0]         m_kind_o,
  output logic               m_last_o
);

  localparam int unsigned CW = $clog2(MAX_STEPS + 1);
  localparam int unsigned DW = CW + 31;

  // operands
  logic [31:0]       b_q [3];
  logic signed [32:0] d_q [3];
  logic [31:0]       tnow_q;
  logic [31:0]       mag [3];
  logic [32:0]       neg_d [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        b_q[i] <= in_data_i[32*i +: 32];
        d_q[i] <= $signed({in_data_i[32*(i+3)+31], in_data_i[32*(i+3) +: 32]})
                - $signed({in_data_i[32*i+31], in_data_i[32*i +: 32]});
      end
      tnow_q <= in_data_i[223:192];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = 33'd0 - d_q[i];
      mag[i]   = d_q[i][32] ? neg_d[i][31:0] : d_q[i][31:0];
    end
  end

  // sums of squares
  logic [31:0]     sq_src;
  logic [63:0]     sq;
  logic [SQ_W-1:0] ssum_q, hsum_q, ssum_add;

  always_comb begin
    case (cmd_i.axis)
      AX_X:    sq_src = mag[0];
      AX_Y:    sq_src = mag[1];
      default: sq_src = mag[2];
    endcase
  end
  assign sq       = sq_src * sq_src;
  assign ssum_add = ssum_q + {2'b00, sq};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      if (cmd_i.axis == AX_X) begin
        ssum_q <= {2'b00, sq};
      end else begin
        ssum_q <= ssum_add;
        if (cmd_i.axis == AX_Y) hsum_q <= ssum_add;
      end
    end
  end

  // square roots
  logic            sqrt_busy;
  logic [RT_W-1:0] root;
  logic [RT_W-1:0] len_q, h_q;

  lqs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.sqrt_start),
    .rad_i  (cmd_i.sqrt_sel ? hsum_q : ssum_q),
    .busy_o (sqrt_busy),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_store) begin
      if (cmd_i.sqrt_sel) h_q <= root;
      else len_q <= root;
    end
  end

  // step count: fewest steps reaching the length, clamped to 2..MAX_STEPS
  logic [30:0]   step_s;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] cacc_q;
  logic          cnt_done;

  assign step_s   = (step_length_i == 31'd0) ? 31'd1 : step_length_i;
  assign cnt_done = (DW'(len_q) <= cacc_q) || (cnt_q == CW'(MAX_STEPS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_init) begin
      cnt_q  <= CW'(2);
      cacc_q <= DW'({step_s, 1'b0});
    end else if (cmd_i.cnt_step) begin
      cnt_q  <= cnt_q + 1'b1;
      cacc_q <= cacc_q + DW'(step_s);
    end
  end

  // shared divider
  logic [NUM_W-1:0] prod_x, prod_y, div_num;
  logic [DW-1:0]    div_den, ctl, uden;
  logic             div_busy;
  logic [NUM_W-1:0] quo;
  logic [DW-1:0]    rem;
  logic             tl_zero;

  assign prod_x  = half_width_i * mag[0];
  assign prod_y  = half_width_i * mag[1];
  assign ctl     = DW'(cnt_q) * DW'(texture_length_i);
  assign tl_zero = (texture_length_i == 31'd0);
  assign uden    = tl_zero ? DW'(cnt_q) : ctl;

  always_comb begin
    div_num = '0;
    div_den = DW'(1);
    case (cmd_i.op)
      OP_OX: begin div_num = prod_y; div_den = DW'(h_q); end
      OP_OY: begin div_num = prod_x; div_den = DW'(h_q); end
      OP_PX: begin div_num = NUM_W'(mag[0]); div_den = DW'(cnt_q); end
      OP_PY: begin div_num = NUM_W'(mag[1]); div_den = DW'(cnt_q); end
      OP_PZ: begin div_num = NUM_W'(mag[2]); div_den = DW'(cnt_q); end
      OP_PU: begin
        div_num = tl_zero ? NUM_W'(len_q) : NUM_W'({len_q, 16'h0000});
        div_den = uden;
      end
      OP_LOOP: begin
        div_num = NUM_W'(len_q);
        div_den = tl_zero ? DW'(65536) : DW'(texture_length_i);
      end
      default: ;
    endcase
  end

  lqs_div #(.NW(NUM_W), .DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (quo),
    .rem_o  (rem)
  );

  logic [30:0]     oxm_q, oym_q;
  logic [31:0]     base_q [3];
  logic [CW-1:0]   base_r [3];
  logic [UQ_W-1:0] ubase_q;
  logic [DW-1:0]   ubase_r;
  logic [RT_W:0]   loop_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      case (cmd_i.op)
        OP_OX: oxm_q <= quo[30:0];
        OP_OY: oym_q <= quo[30:0];
        OP_PX: begin base_q[0] <= quo[31:0]; base_r[0] <= rem[CW-1:0]; end
        OP_PY: begin base_q[1] <= quo[31:0]; base_r[1] <= rem[CW-1:0]; end
        OP_PZ: begin base_q[2] <= quo[31:0]; base_r[2] <= rem[CW-1:0]; end
        OP_PU: begin ubase_q <= quo[UQ_W-1:0]; ubase_r <= rem; end
        OP_LOOP: loop_q <= (RT_W+1)'(quo[RT_W-1:0]) + (RT_W+1)'(rem != '0);
        default: ;
      endcase
    end
  end

  // sideways offset, zero when the direction has no xy part
  logic signed [31:0] ox, oy;
  always_comb begin
    ox = '0;
    oy = '0;
    if (h_q != '0) begin
      ox = d_q[1][32] ? -$signed({1'b0, oxm_q}) : $signed({1'b0, oxm_q});
      oy = d_q[0][32] ? $signed({1'b0, oym_q}) : -$signed({1'b0, oym_q});
    end
  end

  // boundary stepping: accumulators hold boundary kE, B registers hold kE-1
  logic [31:0]     acc_q [3];
  logic [CW-1:0]   accr_q [3];
  logic [CW:0]     accr_sum [3];
  logic            accr_wrap [3];
  logic [UQ_W-1:0] uacc_q;
  logic [DW-1:0]   uaccr_q;
  logic [DW:0]     uaccr_sum;
  logic            uaccr_wrap;
  logic [CW-1:0]   ke_q;

  logic signed [POS_W-1:0] pe [3];
  logic signed [POS_W-1:0] pb_q [3];
  logic signed [U_W-1:0]   ue, bu_q, loop_u, tnow_w;

  assign tnow_w = $signed({{(U_W-32){tnow_q[31]}}, tnow_q});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      accr_sum[i]  = {1'b0, accr_q[i]} + {1'b0, base_r[i]};
      accr_wrap[i] = accr_sum[i] >= {1'b0, cnt_q};
      pe[i] = $signed({{(POS_W-32){b_q[i][31]}}, b_q[i]})
            + (d_q[i][32] ? -$signed({3'b000, acc_q[i]}) : $signed({3'b000, acc_q[i]}));
    end
  end

  assign uaccr_sum  = {1'b0, uaccr_q} + {1'b0, ubase_r};
  assign uaccr_wrap = uaccr_sum >= {1'b0, uden};
  assign ue     = $signed({3'b000, uacc_q}) - tnow_w;
  assign loop_u = $signed({2'b00, loop_q, 16'h0000}) - tnow_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i]  <= '0;
        accr_q[i] <= '0;
      end
      uacc_q  <= '0;
      uaccr_q <= '0;
      ke_q    <= '0;
    end else if (cmd_i.adv) begin
      for (int i = 0; i < 3; i++) begin
        pb_q[i]   <= pe[i];
        acc_q[i]  <= acc_q[i] + base_q[i] + 32'(accr_wrap[i]);
        accr_q[i] <= accr_wrap[i] ? CW'(accr_sum[i] - {1'b0, cnt_q}) : accr_sum[i][CW-1:0];
      end
      bu_q    <= ue;
      uacc_q  <= uacc_q + ubase_q + UQ_W'(uaccr_wrap);
      uaccr_q <= uaccr_wrap ? DW'(uaccr_sum - {1'b0, uden}) : uaccr_sum[DW-1:0];
      ke_q    <= ke_q + 1'b1;
    end
  end

  // vertex assembly
  logic [1:0]          kind;
  logic                use_e, plus, zero, last;
  logic [1:0]          vh;
  logic signed [35:0]  vx, vy, offx, offy;
  logic signed [POS_W-1:0] sx, sy, sz;
  logic signed [U_W-1:0]   uv;
  logic [31:0]         o_x, o_y, o_z, o_u;

  always_comb begin
    if (ke_q == CW'(1)) kind = KIND_FIRST;
    else if (ke_q == cnt_q) kind = KIND_FINAL;
    else kind = KIND_MIDDLE;
    use_e = (cmd_i.corner == CORNER_1) || (cmd_i.corner == CORNER_2);
    plus  = (cmd_i.corner == CORNER_0) || (cmd_i.corner == CORNER_1);
    zero  = ((kind == KIND_FIRST) && !use_e) || ((kind == KIND_FINAL) && use_e);
    vh    = zero ? V_HALF : (plus ? V_ZERO : V_ONE);
    last  = (kind == KIND_FINAL) && (cmd_i.corner == CORNER_3);
    sx    = use_e ? pe[0] : pb_q[0];
    sy    = use_e ? pe[1] : pb_q[1];
    sz    = use_e ? pe[2] : pb_q[2];
    offx  = zero ? 36'sd0 : (plus ? 36'(ox) : -36'(ox));
    offy  = zero ? 36'sd0 : (plus ? 36'(oy) : -36'(oy));
    vx    = 36'(sx) + offx;
    vy    = 36'(sy) + offy;
    if (!use_e) uv = bu_q;
    else if ((kind == KIND_FINAL) && force_tex_loop_i) uv = loop_u;
    else uv = ue;
    o_x = sat32(64'(vx));
    o_y = sat32(64'(vy));
    o_z = sat32(64'(sz));
    o_u = sat32(64'(uv));
  end

  // output register
  logic         m_valid_q;
  logic [135:0] m_data_q;
  logic [1:0]   m_kind_q;
  logic         m_last_q;
  logic         out_free;

  assign out_free = !m_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_data_q <= {4'b0000, cmd_i.corner, vh, o_u, o_z, o_y, o_x};
      m_kind_q <= kind;
      m_last_q <= last;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_kind_o  = m_kind_q;
  assign m_last_o  = m_last_q;

  assign sts_o.sqrt_busy = sqrt_busy;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.cnt_done  = cnt_done;
  assign sts_o.last_step = (ke_q == cnt_q);
  assign sts_o.out_free  = out_free;

endmodule

`default_nettype wire

@@ hdl/line_to_quad_strip_expander.sv @@
// ----------------------------------------------------------------------------
// line_to_quad_strip_expander
// Expands a 3D line segment into a strip of textured quads, four vertices per
// step, in signed Q16.16.
// ----------------------------------------------------------------------------
// One line is taken at a time. After an item is accepted the block squares
// the three axes, runs the bit-serial square root twice (full length, then
// xy length; start, iterations, store each), finds the step count, and runs
// seven divisions in the shared bit-serial divider (offsets, per-axis step,
// U step, looped tail U; start, iterations, store each); then it clears the
// boundary accumulators, and per step advances the boundary and emits 4
// vertices, one per cycle while the output register is free. A new line is
// accepted as soon as the last vertex sits in the output register.
`default_nettype none

module line_to_quad_strip_expander
  import lqs_pkg::*;
#(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // begin_x, begin_y, begin_z, end_x, end_y, end_z, time_now
  input  wire logic [223:0] s_axis_tdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v_halves, corner, zero pad
  output logic [135:0]      m_axis_tdata,
  // segment_kind
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [30:0] half_width_q, step_length_q, texture_length_q;
  logic        force_tex_loop_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q     <= HALF_WIDTH_RST;
      step_length_q    <= STEP_LEN_RST;
      texture_length_q <= TEX_LEN_RST;
      force_tex_loop_q <= 1'b0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_HALF_WIDTH: half_width_q     <= pwdata[30:0];
        REG_STEP_LEN:   step_length_q    <= pwdata[30:0];
        REG_TEX_LEN:    texture_length_q <= pwdata[30:0];
        REG_TEX_LOOP:   force_tex_loop_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HALF_WIDTH: prdata = {1'b0, half_width_q};
      REG_STEP_LEN:   prdata = {1'b0, step_length_q};
      REG_TEX_LEN:    prdata = {1'b0, texture_length_q};
      REG_TEX_LOOP:   prdata = {31'd0, force_tex_loop_q};
      default:        prdata = '0;
    endcase
  end

  lqs_cmd_t cmd;
  lqs_sts_t sts;

  lqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lqs_datapath #(.MAX_STEPS(MAX_STEPS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .half_width_i    (half_width_q),
    .step_length_i   (step_length_q),
    .texture_length_i(texture_length_q),
    .force_tex_loop_i(force_tex_loop_q),
    .in_data_i       (s_axis_tdata),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_data_o        (m_axis_tdata),
    .m_kind_o        (m_axis_tuser),
    .m_last_o        (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ hdl/lqs_checker.sv @@
// ----------------------------------------------------------------------------
// lqs_checker
// Port-level checks of the line to quad strip expander.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_checker
  import lqs_pkg::*;
(
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [135:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser,
  input wire logic         m_axis_tlast,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // one line at a time
  a_in_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second line accepted while busy");

  a_last_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_FINAL)
    else $error("last vertex outside final step");

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[131:130] == CORNER_3)
    else $error("last vertex is not corner 3");

endmodule

bind line_to_quad_strip_expander lqs_checker u_lqs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);

`default_nettype wire

@@ tb/tb_line_to_quad_strip_expander.sv @@
// ----------------------------------------------------------------------------
// tb_line_to_quad_strip_expander
// Self-checking bench: drives lines over the input stream, programs the
// registers over APB, and checks every vertex against a local strip predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_line_to_quad_strip_expander;
  import lqs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEP_CAP    = 16;
  localparam longint      CYCLE_LIMIT = 8_000_000;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [1:0]  tex_v_halves;
    logic [1:0]  corner;
    logic [1:0]  segment_kind;
    logic        last;
  } vertex_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic [223:0]  s_axis_tdata = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [135:0]  m_axis_tdata;
  logic [1:0]    m_axis_tuser;
  logic          m_axis_tlast;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  line_to_quad_strip_expander uut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // shadow registers
  longint half_w, step_len, tex_len;
  logic   tex_loop;

  vertex_t expected_vertices[$];
  int      errors = 0;
  longint  cycles = 0;
  int      rx_stall_req = 0;   // long receiver hold-off, in cycles
  bit      rx_no_idle = 1'b0;
  bit      tx_no_idle = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("line_to_quad_strip_expander: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // strip predictor
  // --------------------------------------------------------------------------
  function automatic logic [31:0] clamp32(longint v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic longint root_floor(logic [67:0] v);
    logic [67:0] r, c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (68'd1 << b);
      if (c * c <= v) r = c;
    end
    return longint'(r);
  endfunction

  function automatic longint u_mark(longint len, longint k, longint count);
    if (tex_len == 0) return len * k / count;
    return ((len * k) << 16) / (count * tex_len);
  endfunction

  function automatic void push_vertex(longint x, longint y, longint z, longint u,
                                      logic [1:0] v, logic [1:0] cn, logic [1:0] kind,
                                      logic lst);
    vertex_t e;
    e.pos_x = clamp32(x);
    e.pos_y = clamp32(y);
    e.pos_z = clamp32(z);
    e.tex_u = clamp32(u);
    e.tex_v_halves = v;
    e.corner = cn;
    e.segment_kind = kind;
    e.last = lst;
    expected_vertices.insert(expected_vertices.size(), e);
  endfunction

  function automatic void predict_strip(logic [223:0] w);
    longint      org[3], dir[3], p0[3], p1[3];
    longint      mag, tnow, len, h, s, count, ox, oy, ub, ue, t;
    logic [67:0] sum_all, sum_xy, sq;
    logic [1:0]  kind;
    sum_all = '0;
    sum_xy = '0;
    for (int i = 0; i < 3; i++) begin
      org[i] = longint'($signed(w[32*i +: 32]));
      dir[i] = longint'($signed(w[32*(i+3) +: 32])) - org[i];
      mag = dir[i] < 0 ? -dir[i] : dir[i];
      sq = 68'(mag) * 68'(mag);
      sum_all += sq;
      if (i < 2) sum_xy += sq;
    end
    tnow = longint'($signed(w[223:192]));
    len = root_floor(sum_all);
    h = root_floor(sum_xy);
    s = step_len != 0 ? step_len : 1;
    if (len <= 2 * s) count = 2;
    else begin
      count = (len + s - 1) / s;
      if (count > STEP_CAP) count = STEP_CAP;
    end
    ox = 0;
    oy = 0;
    if (h != 0) begin
      ox = (half_w * dir[1]) / h;
      oy = -((half_w * dir[0]) / h);
    end
    for (longint k = 0; k < count; k++) begin
      kind = (k == 0) ? KIND_FIRST : (k == count - 1) ? KIND_FINAL : KIND_MIDDLE;
      for (int i = 0; i < 3; i++) begin
        p0[i] = org[i] + (dir[i] * k) / count;
        p1[i] = org[i] + (dir[i] * (k + 1)) / count;
      end
      ub = u_mark(len, k, count) - tnow;
      if (kind == KIND_FINAL && tex_loop) begin
        t = tex_len != 0 ? tex_len : 65536;
        ue = (((len + t - 1) / t) << 16) - tnow;
      end else begin
        ue = u_mark(len, k + 1, count) - tnow;
      end
      case (kind)
        KIND_FIRST: begin
          push_vertex(p0[0], p0[1], p0[2], ub, V_HALF, CORNER_0, kind, 1'b0);
          push_vertex(p1[0] + ox, p1[1] + oy, p1[2], ue, V_ZERO, CORNER_1, kind, 1'b0);
          push_vertex(p1[0] - ox, p1[1] - oy, p1[2], ue, V_ONE, CORNER_2, kind, 1'b0);
          push_vertex(p0[0], p0[1], p0[2], ub, V_HALF, CORNER_3, kind, 1'b0);
        end
        KIND_MIDDLE: begin
          push_vertex(p0[0] + ox, p0[1] + oy, p0[2], ub, V_ZERO, CORNER_0, kind, 1'b0);
          push_vertex(p1[0] + ox, p1[1] + oy, p1[2], ue, V_ZERO, CORNER_1, kind, 1'b0);
          push_vertex(p1[0] - ox, p1[1] - oy, p1[2], ue, V_ONE, CORNER_2, kind, 1'b0);
          push_vertex(p0[0] - ox, p0[1] - oy, p0[2], ub, V_ONE, CORNER_3, kind, 1'b0);
        end
        default: begin
          push_vertex(p0[0] + ox, p0[1] + oy, p0[2], ub, V_ZERO, CORNER_0, kind, 1'b0);
          push_vertex(p1[0], p1[1], p1[2], ue, V_HALF, CORNER_1, kind, 1'b0);
          push_vertex(p1[0], p1[1], p1[2], ue, V_HALF, CORNER_2, kind, 1'b0);
          push_vertex(p0[0] - ox, p0[1] - oy, p0[2], ub, V_ONE, CORNER_3, kind, 1'b1);
        end
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // output side: ready generator and vertex checker
  // --------------------------------------------------------------------------
  int rx_gap = 0;
  always @(posedge clk_i) begin
    if (rx_stall_req != 0) begin
      rx_gap = rx_stall_req;
      rx_stall_req = 0;
    end
    if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_no_idle) begin
        if ($urandom_range(0, 63) == 0) rx_gap = $urandom_range(20, 80);
        else if ($urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 3);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_vertices.size() == 0) begin
        $error("vertex with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        e = expected_vertices.pop_front();
        check_field("pos_x", e.pos_x, m_axis_tdata[31:0]);
        check_field("pos_y", e.pos_y, m_axis_tdata[63:32]);
        check_field("pos_z", e.pos_z, m_axis_tdata[95:64]);
        check_field("tex_u", e.tex_u, m_axis_tdata[127:96]);
        check_field("tex_v_halves", 32'(e.tex_v_halves), 32'(m_axis_tdata[129:128]));
        check_field("corner", 32'(e.corner), 32'(m_axis_tdata[131:130]));
        check_field("segment_kind", 32'(e.segment_kind), 32'(m_axis_tuser));
        check_field("last", 32'(e.last), 32'(m_axis_tlast));
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  // called right after a rising edge; returns right after one too
  task automatic send_line(logic [223:0] w);
    int g;
    s_axis_tdata <= w;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_strip(w);
    g = 0;
    if (!tx_no_idle) begin
      if ($urandom_range(0, 31) == 0) g = $urandom_range(20, 200);
      else if ($urandom_range(0, 3) == 0) g = $urandom_range(1, 4);
    end
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HALF_WIDTH: half_w = longint'(val[30:0]);
      REG_STEP_LEN:   step_len = longint'(val[30:0]);
      REG_TEX_LEN:    tex_len = longint'(val[30:0]);
      default:        tex_loop = val[0];
    endcase
  endtask

  task automatic set_config(logic [31:0] hw, logic [31:0] sl, logic [31:0] tl, logic lp);
    wait_drained();
    reg_write(REG_HALF_WIDTH, hw);
    reg_write(REG_STEP_LEN, sl);
    reg_write(REG_TEX_LEN, tl);
    reg_write(REG_TEX_LOOP, {31'd0, lp});
  endtask

  function automatic logic [223:0] pack_line(logic [31:0] bx, logic [31:0] by,
                                             logic [31:0] bz, logic [31:0] ex,
                                             logic [31:0] ey, logic [31:0] ez,
                                             logic [31:0] tn);
    return {tn, ez, ey, ex, bz, by, bx};
  endfunction

  function automatic logic [31:0] rand_delta(int span_bits);
    logic [31:0] d;
    d = $urandom() & ((32'd1 << span_bits) - 1);
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  function automatic logic [223:0] rand_line();
    logic [31:0] bx, by, bz, tn;
    int          span;
    bx = $urandom();
    by = $urandom();
    bz = $urandom();
    tn = $urandom_range(0, 3) == 0 ? $urandom() : rand_delta(22);
    case ($urandom_range(0, 9))
      0, 1: return pack_line(bx, by, bz, $urandom(), $urandom(), $urandom(), tn);
      2: return pack_line(bx, by, bz, bx, by, bz + rand_delta(24), tn);   // vertical
      3: return pack_line(bx, by, bz, bx, by, bz, tn);                    // point
      default: begin
        span = $urandom_range(12, 24);
        return pack_line(bx, by, bz, bx + rand_delta(span), by + rand_delta(span),
                         bz + rand_delta(span), tn);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed_lines();
    send_line(pack_line(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
    send_line(pack_line(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_line(pack_line(0, 0, 0, 0, 0, 0, 32'h8000_0000));              // zero length
    send_line(pack_line(32'h1_0000, 32'h2_0000, 0, 32'h1_0000, 32'h2_0000,
                        32'h9_0000, 0));                                 // vertical
    send_line(pack_line(0, 0, 0, 32'h3_0000, 0, 0, 32'h1_8000));         // along x
    send_line(pack_line(0, 0, 0, 0, 32'hFFFD_0000, 0, 0));               // along -y
    send_line(pack_line(0, 0, 0, 32'h4_0000, 0, 0, 0));                  // exactly 2 steps
    send_line(pack_line(0, 0, 0, 32'h4_0001, 0, 0, 0));                  // 3 steps
    send_line(pack_line(0, 0, 0, 32'h40_0000, 32'h40_0000, 0, 0));       // saturated count
    send_line(pack_line(32'h7FFF_0000, 0, 0, 32'h8000_0000, 32'h10_0000, 0,
                        32'h7FFF_FFFF));
    send_line(pack_line(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                        32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000));
  endtask

  task automatic test_register_extremes();
    // tiny texture length and huge width push U and positions into saturation
    set_config(32'h7FFF_FFFF, 32'd1, 32'd1, 1'b1);
    test_directed_lines();
    set_config(32'd0, 32'd0, 32'd0, 1'b0);          // zero step length acts as one
    test_directed_lines();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    test_directed_lines();
    set_config(32'd0, 32'h7FFF_FFFF, 32'd0, 1'b1);
    repeat (8) send_line(rand_line());
  endtask

  task automatic test_random_lines(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        tx_no_idle = (i % 120 == 40);
        rx_no_idle = (i % 120 == 80);
        set_config($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h4_0000),
                   $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 32'h20_0000),
                   $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h8_0000),
                   1'($urandom_range(0, 1)));
      end
      send_line(rand_line());
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    tx_no_idle = 1'b1;
    rx_stall_req = 3000;
    repeat (6) send_line(rand_line());
    tx_no_idle = 1'b0;
    wait_drained();
  endtask

  initial begin
    ref_defaults();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_lines();
    test_register_extremes();
    test_output_backpressure();
    test_random_lines(360);
    wait_drained();
    if (errors == 0) begin
      $display("line_to_quad_strip_expander: match");
    end else begin
      $display("line_to_quad_strip_expander: mismatch");
    end
    $finish;
  end

  task automatic ref_defaults();
    half_w = longint'(HALF_WIDTH_RST);
    step_len = longint'(STEP_LEN_RST);
    tex_len = longint'(TEX_LEN_RST);
    tex_loop = 1'b0;
  endtask

endmodule

`default_nettype wire
